[rtl/core/group_exclusive_capacity_arbiter_unit_macros.svh]
// Assertion macros shared by the arbiter RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef GROUP_EXCLUSIVE_CAPACITY_ARBITER_UNIT_MACROS_SVH
`define GROUP_EXCLUSIVE_CAPACITY_ARBITER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GECARB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GECARB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/gecarb_pkg.sv]
// Types, constants and codes of the group-exclusive capacity arbiter.
// No dependencies; used by the other RTL files apart from the macro header.
package gecarb_pkg;

    localparam int G_COUNT      = 3;
    localparam int MAX_WAITING  = 16;
    localparam int MAX_CAPACITY = 8;
    localparam int CLASS_W      = 2;
    localparam int CNT_W        = 4;
    localparam int WAIT_W       = $clog2(MAX_WAITING + 1);

    localparam logic [CLASS_W-1:0] OWNER_FREE    = 2'd3;
    localparam logic [CLASS_W-1:0] CLASS_INVALID = 2'd3;

    localparam logic FUNC_ENTER = 1'b0;
    localparam logic FUNC_LEAVE = 1'b1;

    localparam logic [1:0] CFG_CAP_CLASS0 = 2'd0;
    localparam logic [1:0] CFG_CAP_CLASS1 = 2'd1;
    localparam logic [1:0] CFG_CAP_CLASS2 = 2'd2;

    typedef enum logic [1:0] {
        FAULT_NONE        = 2'd0,
        FAULT_WAIT_FULL   = 2'd1,
        FAULT_LEAVE_EMPTY = 2'd2
    } t_fault;

    typedef logic [G_COUNT-1:0][CNT_W-1:0] t_cap_set;

    localparam t_cap_set CAP_RESET = {4'd1, 4'd2, 4'd4};

    typedef struct packed {
        logic               func;
        logic [CLASS_W-1:0] req_class;
    } t_item;

    typedef struct packed {
        logic               admitted_now;
        logic               queued;
        logic [CLASS_W-1:0] grant_class;
        logic [CNT_W-1:0]   grant_count;
        logic [CLASS_W-1:0] owner_class;
        logic [CNT_W-1:0]   active_holders;
        t_fault             fault;
    } t_result;

endpackage

[rtl/core/gecarb_if.sv]
// Handshake interfaces for the request, result and configuration channels.
// Depends on gecarb_pkg for field widths.
interface gecarb_in_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [gecarb_pkg::CLASS_W-1:0]      req_class;

    modport source (output valid, output func, output req_class, input ready);
    modport sink (input valid, input func, input req_class, output ready);
endinterface

interface gecarb_out_if;
    logic                                valid;
    logic                                ready;
    logic                                admitted_now;
    logic                                queued;
    logic [gecarb_pkg::CLASS_W-1:0]      grant_class;
    logic [gecarb_pkg::CNT_W-1:0]        grant_count;
    logic [gecarb_pkg::CLASS_W-1:0]      owner_class;
    logic [gecarb_pkg::CNT_W-1:0]        active_holders;
    logic [1:0]                          fault;

    modport source (
        output valid, output admitted_now, output queued, output grant_class,
        output grant_count, output owner_class, output active_holders,
        output fault, input ready
    );
    modport sink (
        input valid, input admitted_now, input queued, input grant_class,
        input grant_count, input owner_class, input active_holders,
        input fault, output ready
    );
endinterface

interface gecarb_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          reg_index;
    logic [gecarb_pkg::CNT_W-1:0]        data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink (input valid, input reg_index, input data, output ready);
endinterface

[rtl/core/gecarb_cfg.sv]
// Capacity registers of the three classes and their clamping to the legal range.
// Depends on gecarb_pkg.
module gecarb_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [1:0]                    i_wr_index,
    input  logic [gecarb_pkg::CNT_W-1:0]  i_wr_data,
    output gecarb_pkg::t_cap_set          o_cap
);

    gecarb_pkg::t_cap_set r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= gecarb_pkg::CAP_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                gecarb_pkg::CFG_CAP_CLASS0: r_cap[0] <= i_wr_data;
                gecarb_pkg::CFG_CAP_CLASS1: r_cap[1] <= i_wr_data;
                gecarb_pkg::CFG_CAP_CLASS2: r_cap[2] <= i_wr_data;
                default: r_cap <= r_cap;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < gecarb_pkg::G_COUNT; k++) begin
            if (r_cap[k] == '0) begin
                o_cap[k] = gecarb_pkg::CNT_W'(1);
            end else if (r_cap[k] > gecarb_pkg::CNT_W'(gecarb_pkg::MAX_CAPACITY)) begin
                o_cap[k] = gecarb_pkg::CNT_W'(gecarb_pkg::MAX_CAPACITY);
            end else begin
                o_cap[k] = r_cap[k];
            end
        end
    end

endmodule

[rtl/core/gecarb_engine.sv]
// Arbitration state (owner, holders, waiters, round-robin pointer) and the
// combinational step that updates it. Depends on gecarb_pkg and the macro header.
`include "group_exclusive_capacity_arbiter_unit_macros.svh"

module gecarb_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  gecarb_pkg::t_item     i_item,
    input  gecarb_pkg::t_cap_set  i_cap,
    output gecarb_pkg::t_result   o_result
);

    logic [gecarb_pkg::CLASS_W-1:0] r_owner;
    logic [gecarb_pkg::CLASS_W-1:0] r_last;
    logic [gecarb_pkg::CNT_W-1:0]   r_active;
    logic [gecarb_pkg::WAIT_W-1:0]  r_wait [gecarb_pkg::G_COUNT];

    logic [gecarb_pkg::CLASS_W-1:0] n_owner;
    logic [gecarb_pkg::CLASS_W-1:0] n_last;
    logic [gecarb_pkg::CNT_W-1:0]   n_active;
    logic [gecarb_pkg::WAIT_W-1:0]  n_wait [gecarb_pkg::G_COUNT];

    gecarb_pkg::t_result            res;
    logic [gecarb_pkg::CLASS_W-1:0] cls;
    logic                           others_busy;
    logic [gecarb_pkg::CLASS_W-1:0] rr_base;
    logic [2:0]                     rr_idx;
    logic [gecarb_pkg::CLASS_W-1:0] pick;
    logic                           pick_found;
    logic [gecarb_pkg::CNT_W-1:0]   grant_n;
    logic [gecarb_pkg::CNT_W-1:0]   active_dec;

    assign cls = i_item.req_class;

    always_comb begin
        others_busy = 1'b0;
        for (int k = 0; k < gecarb_pkg::G_COUNT; k++) begin
            if (gecarb_pkg::CLASS_W'(k) != cls && r_wait[k] != '0) begin
                others_busy = 1'b1;
            end
        end
    end

    // The scan starts after the last served class and wraps around.
    always_comb begin
        if (r_last == gecarb_pkg::OWNER_FREE ||
            r_last == gecarb_pkg::CLASS_W'(gecarb_pkg::G_COUNT - 1)) begin
            rr_base = '0;
        end else begin
            rr_base = r_last + 1'b1;
        end
        pick       = '0;
        pick_found = 1'b0;
        rr_idx     = '0;
        for (int s = 0; s < gecarb_pkg::G_COUNT; s++) begin
            rr_idx = {1'b0, rr_base} + 3'(s);
            if (rr_idx >= 3'(gecarb_pkg::G_COUNT)) begin
                rr_idx = rr_idx - 3'(gecarb_pkg::G_COUNT);
            end
            if (!pick_found && r_wait[rr_idx[1:0]] != '0) begin
                pick       = rr_idx[1:0];
                pick_found = 1'b1;
            end
        end
        if (r_wait[pick] < {1'b0, i_cap[pick]}) begin
            grant_n = r_wait[pick][gecarb_pkg::CNT_W-1:0];
        end else begin
            grant_n = i_cap[pick];
        end
    end

    assign active_dec = r_active - 1'b1;

    always_comb begin
        n_owner  = r_owner;
        n_last   = r_last;
        n_active = r_active;
        n_wait   = r_wait;
        res      = '0;
        if (cls != gecarb_pkg::CLASS_INVALID) begin
            if (i_item.func == gecarb_pkg::FUNC_ENTER) begin
                if (r_owner == gecarb_pkg::OWNER_FREE ||
                    (r_owner == cls && r_active < i_cap[cls] && !others_busy)) begin
                    if (r_owner == gecarb_pkg::OWNER_FREE) begin
                        n_owner = cls;
                        n_last  = cls;
                    end
                    if (r_active != '1) begin
                        n_active = r_active + 1'b1;
                    end
                    res.admitted_now = 1'b1;
                end else if (r_wait[cls] >= gecarb_pkg::WAIT_W'(gecarb_pkg::MAX_WAITING)) begin
                    res.fault = gecarb_pkg::FAULT_WAIT_FULL;
                end else begin
                    n_wait[cls] = r_wait[cls] + 1'b1;
                    res.queued  = 1'b1;
                end
            end else if (r_active == '0) begin
                res.fault = gecarb_pkg::FAULT_LEAVE_EMPTY;
            end else if (active_dec == '0) begin
                if (!pick_found) begin
                    n_owner  = gecarb_pkg::OWNER_FREE;
                    n_active = '0;
                end else begin
                    n_owner          = pick;
                    n_last           = pick;
                    n_wait[pick]     = r_wait[pick] - {1'b0, grant_n};
                    n_active         = grant_n;
                    res.grant_class  = pick;
                    res.grant_count  = grant_n;
                end
            end else if (!others_busy && r_wait[cls] != '0) begin
                // One holder leaves and one waiter of the same class takes its slot.
                n_wait[cls]     = r_wait[cls] - 1'b1;
                n_active        = r_active;
                res.grant_class = cls;
                res.grant_count = gecarb_pkg::CNT_W'(1);
            end else begin
                n_active = active_dec;
            end
        end
        res.owner_class    = n_owner;
        res.active_holders = n_active;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner  <= gecarb_pkg::OWNER_FREE;
            r_last   <= gecarb_pkg::OWNER_FREE;
            r_active <= '0;
            for (int k = 0; k < gecarb_pkg::G_COUNT; k++) begin
                r_wait[k] <= '0;
            end
        end else if (i_fire) begin
            r_owner  <= n_owner;
            r_last   <= n_last;
            r_active <= n_active;
            r_wait   <= n_wait;
        end
    end

    `GECARB_ASSERT_IMPL(a_free_has_no_holders, i_clk, i_rst_n, r_owner == gecarb_pkg::OWNER_FREE, r_active == '0, "free resource with active holders")
    `GECARB_ASSERT_IMPL(a_grant_within_cap, i_clk, i_rst_n, i_fire && res.grant_count != '0, res.grant_count <= i_cap[res.grant_class], "grant exceeds class capacity")
    `GECARB_ASSERT_NEXT(a_fault_keeps_state, i_clk, i_rst_n, i_fire && res.fault != gecarb_pkg::FAULT_NONE, r_active == $past(r_active) && r_owner == $past(r_owner), "faulting transaction changed state")

endmodule

[rtl/core/group_exclusive_capacity_arbiter_unit.sv]
// Group-exclusive capacity arbiter: one request transaction in, one result
// transaction out. Each transaction is held in the input register and leaves
// from the result register, and a new request is taken every cycle while the
// consumer takes results; the update of the owner, holder and waiter registers
// at each step sets that rate. While the consumer stalls, the
// block holds the waiting result and at most one more request in the input
// register, after which the request channel stalls as well. The
// configuration channel is always ready and must be written while no request
// is in flight. After reset the block is ready at once; no clearing pass runs.
module group_exclusive_capacity_arbiter_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gecarb_in_if.sink             i_in,
    gecarb_cfg_if.sink            i_cfg,
    gecarb_out_if.source          o_out
);

    logic                  r_in_valid;
    gecarb_pkg::t_item     r_item;
    logic                  r_out_valid;
    gecarb_pkg::t_result   r_result;

    logic                  in_fire;
    logic                  advance;
    gecarb_pkg::t_cap_set  cap;
    gecarb_pkg::t_result   step_result;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_fire    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    gecarb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.reg_index),
        .i_wr_data  (i_cfg.data),
        .o_cap      (cap)
    );

    gecarb_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_item),
        .i_cap    (cap),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.func      <= i_in.func;
            r_item.req_class <= i_in.req_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.admitted_now   = r_result.admitted_now;
    assign o_out.queued         = r_result.queued;
    assign o_out.grant_class    = r_result.grant_class;
    assign o_out.grant_count    = r_result.grant_count;
    assign o_out.owner_class    = r_result.owner_class;
    assign o_out.active_holders = r_result.active_holders;
    assign o_out.fault          = r_result.fault;

endmodule
